// ===== rtl/core/sfr_pkg.sv =====
package sfr_pkg;

  // Frame geometry
  localparam int FRAME_LEN = 16;
  localparam int POS_W     = $clog2(FRAME_LEN);

  localparam logic [7:0]  START_BYTE = 8'h02;
  localparam logic [7:0]  END_BYTE   = 8'h03;
  localparam logic [15:0] CNT_MAX    = 16'hFFFF;

  // Position of the check byte and of the end byte
  localparam logic [POS_W-1:0] CHK_POS = POS_W'(FRAME_LEN - 2);
  localparam logic [POS_W-1:0] END_POS = POS_W'(FRAME_LEN - 1);

  typedef enum logic [1:0] {
    OP_BYTE = 2'd0,
    OP_IDLE = 2'd1,
    OP_TICK = 2'd2
  } sfr_op_t;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] rx_byte;
  } sfr_item_t;

  typedef struct packed {
    logic [7:0]  byte_out;
    logic [3:0]  byte_pos;
    logic        byte_kept;
    logic        frame_end;
    logic        frame_good;
    logic [15:0] error_total;
    logic        link_lost;
    logic [15:0] lost_ticks;
  } sfr_result_t;

  function automatic logic [15:0] sat_inc(input logic [15:0] v);
    sat_inc = (v == CNT_MAX) ? v : v + 16'd1;
  endfunction

endpackage

// ===== rtl/core/sfr_in_if.sv =====
interface sfr_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [7:0] rx_byte;

  modport source (output valid, output op, output rx_byte, input ready);
  modport sink   (input valid, input op, input rx_byte, output ready);
endinterface

// ===== rtl/core/sfr_out_if.sv =====
interface sfr_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  byte_out;
  logic [3:0]  byte_pos;
  logic        byte_kept;
  logic        frame_end;
  logic        frame_good;
  logic [15:0] error_total;
  logic        link_lost;
  logic [15:0] lost_ticks;

  modport source (output valid, output byte_out, output byte_pos, output byte_kept,
                  output frame_end, output frame_good, output error_total,
                  output link_lost, output lost_ticks, input ready);
  modport sink   (input valid, input byte_out, input byte_pos, input byte_kept,
                  input frame_end, input frame_good, input error_total,
                  input link_lost, input lost_ticks, output ready);
endinterface

// ===== rtl/core/sfr_in_reg.sv =====
module sfr_in_reg
  import sfr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  sfr_item_t in_item,
  output logic      in_ready,
  input  logic      move,
  output logic      held_valid,
  output sfr_item_t held_item
);

  logic      valid_r, valid_nxt;
  sfr_item_t item_r;

  assign in_ready  = !valid_r || move;
  assign valid_nxt = in_ready ? in_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

  assign held_valid = valid_r;
  assign held_item  = item_r;

endmodule

// ===== rtl/core/sfr_frame_core.sv =====
module sfr_frame_core
  import sfr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        fire,
  input  sfr_item_t   item,
  output sfr_result_t result
);

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [7:0]       sum_r, sum_nxt;
  logic [7:0]       chk_r, chk_nxt;
  logic             good_r, good_nxt;
  logic [15:0]      err_r, err_nxt;
  logic             lost_r, lost_nxt;
  logic [15:0]      lcnt_r, lcnt_nxt;
  logic [7:0]       echo;
  logic [3:0]       bpos;
  logic             kept;
  logic             fend;
  logic [7:0]       b;

  assign b = item.rx_byte;

  always_comb begin
    pos_nxt  = pos_r;
    sum_nxt  = sum_r;
    chk_nxt  = chk_r;
    good_nxt = good_r;
    err_nxt  = err_r;
    lost_nxt = lost_r;
    lcnt_nxt = lcnt_r;
    echo     = 8'd0;
    bpos     = 4'd0;
    kept     = 1'b0;
    fend     = 1'b0;
    unique case (item.op)
      OP_BYTE: begin
        lost_nxt = 1'b0;
        lcnt_nxt = 16'd0;
        echo     = b;
        bpos     = 4'(pos_r);
        if (pos_r == '0) begin
          // hunting: only a start byte opens a frame
          if (b == START_BYTE) begin
            kept    = 1'b1;
            sum_nxt = b;
            pos_nxt = POS_W'(1);
          end else begin
            err_nxt = sat_inc(err_r);
          end
        end else begin
          kept = 1'b1;
          if (pos_r < CHK_POS) begin
            sum_nxt = sum_r + b;
            pos_nxt = pos_r + POS_W'(1);
          end else if (pos_r == CHK_POS) begin
            chk_nxt = b;
            pos_nxt = pos_r + POS_W'(1);
          end else begin
            fend    = 1'b1;
            pos_nxt = '0;
            if (b == END_BYTE && (sum_r + chk_r) == 8'd0) begin
              good_nxt = 1'b1;
              err_nxt  = 16'd0;
            end else begin
              good_nxt = 1'b0;
              err_nxt  = sat_inc(err_r);
            end
          end
        end
      end
      OP_IDLE: begin
        lost_nxt = 1'b1;
      end
      OP_TICK: begin
        if (lost_r) begin
          lcnt_nxt = sat_inc(lcnt_r);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      sum_r  <= 8'd0;
      good_r <= 1'b0;
      err_r  <= 16'd0;
      lost_r <= 1'b0;
      lcnt_r <= 16'd0;
    end else if (fire) begin
      pos_r  <= pos_nxt;
      sum_r  <= sum_nxt;
      good_r <= good_nxt;
      err_r  <= err_nxt;
      lost_r <= lost_nxt;
      lcnt_r <= lcnt_nxt;
    end
  end

  // check byte is always written before the end byte reads it
  always_ff @(posedge clk) begin
    if (fire) begin
      chk_r <= chk_nxt;
    end
  end

  always_comb begin
    result.byte_out    = echo;
    result.byte_pos    = bpos;
    result.byte_kept   = kept;
    result.frame_end   = fend;
    result.frame_good  = good_nxt;
    result.error_total = err_nxt;
    result.link_lost   = lost_nxt;
    result.lost_ticks  = lcnt_nxt;
  end

endmodule

// ===== rtl/core/sfr_out_reg.sv =====
module sfr_out_reg
  import sfr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        move,
  input  sfr_result_t result,
  output logic        out_free,
  output logic        out_valid,
  input  logic        out_ready,
  output sfr_result_t out_result
);

  logic        valid_r, valid_nxt;
  sfr_result_t res_r;

  assign out_free  = !valid_r || out_ready;
  assign valid_nxt = move ? 1'b1 : (out_ready ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      res_r <= result;
    end
  end

  assign out_valid  = valid_r;
  assign out_result = res_r;

endmodule

// ===== rtl/core/stx_etx_frame_receiver.sv =====
// Channel | dir | handshake         | payload
// in_ch   | in  | valid / ready     | op, rx_byte
// out_ch  | out | valid / ready     | byte_out, byte_pos, byte_kept, frame_end,
//         |     |                   | frame_good, error_total, link_lost, lost_ticks
//
// One item per cycle sustained while out_ch is ready; an accepted item passes the input register,
// then the frame logic into the result register, before out_ch shows it valid.
// The frame state updates once per item as it moves into the result register.
// Reset (rst_n low, synchronous) empties both registers and returns to hunting.
// An output stall holds the result; the input register absorbs one more item.
module stx_etx_frame_receiver
  import sfr_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  sfr_in_if.sink    in_ch,
  sfr_out_if.source out_ch
);

  sfr_item_t   in_item;
  sfr_item_t   held_item;
  sfr_result_t result;
  sfr_result_t out_result;
  logic        held_valid;
  logic        out_free;
  logic        move;
  logic        in_ready;
  logic        out_valid;

  assign in_item.op      = in_ch.op;
  assign in_item.rx_byte = in_ch.rx_byte;
  assign in_ch.ready     = in_ready;

  // item leaves the input register when the result register can take it
  assign move = held_valid && out_free;

  sfr_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_item    (in_item),
    .in_ready   (in_ready),
    .move       (move),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  sfr_frame_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (move),
    .item   (held_item),
    .result (result)
  );

  sfr_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .move       (move),
    .result     (result),
    .out_free   (out_free),
    .out_valid  (out_valid),
    .out_ready  (out_ch.ready),
    .out_result (out_result)
  );

  assign out_ch.valid       = out_valid;
  assign out_ch.byte_out    = out_result.byte_out;
  assign out_ch.byte_pos    = out_result.byte_pos;
  assign out_ch.byte_kept   = out_result.byte_kept;
  assign out_ch.frame_end   = out_result.frame_end;
  assign out_ch.frame_good  = out_result.frame_good;
  assign out_ch.error_total = out_result.error_total;
  assign out_ch.link_lost   = out_result.link_lost;
  assign out_ch.lost_ticks  = out_result.lost_ticks;

endmodule

// ===== rtl/core/sfr_checker.sv =====
module sfr_checker
  import sfr_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic [3:0]  byte_pos,
  input logic        byte_kept,
  input logic        frame_end,
  input logic        frame_good,
  input logic [15:0] error_total,
  input logic        link_lost,
  input logic [15:0] lost_ticks
);

  // nothing comes out in the cycle after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

  // frame end only on a kept byte at the last position
  a_end_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && frame_end) |-> (byte_kept && byte_pos == 4'(END_POS)))
    else $error("frame end off the last position");

  // a good frame clears the error count
  a_good_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && frame_end && frame_good) |-> (error_total == 16'd0))
    else $error("error count not cleared by good frame");

  // lost time only accrues while the link is lost
  a_lost_ticks: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !link_lost) |-> (lost_ticks == 16'd0))
    else $error("lost ticks with link up");

endmodule

bind stx_etx_frame_receiver sfr_checker u_sfr_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .byte_pos    (out_ch.byte_pos),
  .byte_kept   (out_ch.byte_kept),
  .frame_end   (out_ch.frame_end),
  .frame_good  (out_ch.frame_good),
  .error_total (out_ch.error_total),
  .link_lost   (out_ch.link_lost),
  .lost_ticks  (out_ch.lost_ticks)
);

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import sfr_pkg::*;

  // Spare op code: the block must ignore it and report status only
  localparam logic [1:0] OP_SPARE = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;

  typedef enum int {FR_GOOD, FR_BAD_END, FR_BAD_SUM, FR_BAD_BOTH} frame_kind_t;

  logic clk = 1'b0;
  logic rst_n;

  sfr_in_if  in_ch ();
  sfr_out_if out_ch ();

  stx_etx_frame_receiver DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Stimulus stream and the results the receiver owes us
  // ---------------------------------------------------------------------------
  sfr_item_t   stream_q[$];      // items waiting to be offered on in_ch
  sfr_result_t due_results[$];   // predicted results, oldest first

  int items_queued  = 0;         // everything pushed to stream_q
  int useful_queued = 0;         // same, less the spare op code
  int items_taken   = 0;         // accepted by the receiver
  int results_seen  = 0;
  int bad_results   = 0;

  int send_idle_pct = 0;         // chance per cycle that the sender holds off
  int recv_idle_pct = 0;         // chance per cycle that ready is dropped

  bit in_took;                   // in_ch item accepted at the last rising edge

  // ---------------------------------------------------------------------------
  // Frame tracker: our own copy of the receiver's state
  // ---------------------------------------------------------------------------
  int unsigned frame_at    = 0;  // next byte position, 0 = hunting for STX
  logic [7:0]  run_sum     = '0; // sum of positions 0..FRAME_LEN-3
  logic [7:0]  held_check  = '0; // byte at the check position
  logic        last_good   = 1'b0;
  logic [15:0] err_run     = '0;
  logic        link_down   = 1'b0;
  logic [15:0] down_ticks  = '0;

  // run statistics for the summary
  int frames_good = 0;
  int frames_bad  = 0;
  int hunt_drops  = 0;
  logic [15:0] peak_err   = '0;
  logic [15:0] peak_ticks = '0;

  task automatic track_frame(input sfr_item_t it, output sfr_result_t res);
    res = '0;
    case (it.op)
      OP_BYTE: begin
        // any byte means the link is alive again
        link_down  = 1'b0;
        down_ticks = '0;
        res.byte_out = it.rx_byte;
        res.byte_pos = 4'(frame_at);
        if (frame_at == 0) begin
          if (it.rx_byte == START_BYTE) begin
            res.byte_kept = 1'b1;
            run_sum       = it.rx_byte;
            frame_at      = 1;
          end else begin
            // stray byte while hunting: dropped, counts as an error
            hunt_drops++;
            if (err_run != CNT_MAX) err_run++;
          end
        end else begin
          res.byte_kept = 1'b1;
          if (frame_at < FRAME_LEN - 2) begin
            run_sum  = run_sum + it.rx_byte;
            frame_at = frame_at + 1;
          end else if (frame_at == FRAME_LEN - 2) begin
            held_check = it.rx_byte;
            frame_at   = frame_at + 1;
          end else begin
            // last byte: ETX and a zero total make a good frame
            res.frame_end = 1'b1;
            if (it.rx_byte == END_BYTE && 8'(run_sum + held_check) == 8'd0) begin
              last_good = 1'b1;
              err_run   = '0;
              frames_good++;
            end else begin
              last_good = 1'b0;
              if (err_run != CNT_MAX) err_run++;
              frames_bad++;
            end
            frame_at = 0;
          end
        end
      end
      OP_IDLE: link_down = 1'b1;
      OP_TICK: if (link_down && down_ticks != CNT_MAX) down_ticks++;
      default: ;
    endcase
    res.frame_good  = last_good;
    res.error_total = err_run;
    res.link_lost   = link_down;
    res.lost_ticks  = down_ticks;
    if (err_run > peak_err) peak_err = err_run;
    if (down_ticks > peak_ticks) peak_ticks = down_ticks;
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus builders
  // ---------------------------------------------------------------------------
  task automatic push_item(input logic [1:0] op, input logic [7:0] b);
    sfr_item_t it;
    it.op      = op;
    it.rx_byte = b;
    stream_q.push_back(it);
    items_queued++;
    if (op != OP_SPARE) useful_queued++;
  endtask

  function automatic logic [7:0] not_start();
    logic [7:0] b;
    do b = 8'($urandom); while (b == START_BYTE);
    return b;
  endfunction

  // occasionally slip a poll, tick or spare op in between frame bytes
  task automatic push_stray(input int pct);
    int r;
    if ($urandom_range(0, 99) < pct) begin
      r = $urandom_range(0, 2);
      push_item(r == 0 ? OP_IDLE : (r == 1 ? OP_TICK : OP_SPARE), 8'($urandom));
    end
  endtask

  // fill < 0 gives random payload, otherwise every payload byte is fill
  task automatic push_frame(input frame_kind_t kind, input int fill, input int stray_pct);
    logic [7:0] sum;
    logic [7:0] b;
    sum = START_BYTE;
    push_stray(stray_pct);
    push_item(OP_BYTE, START_BYTE);
    for (int i = 1; i <= FRAME_LEN - 3; i++) begin
      b   = (fill < 0) ? 8'($urandom) : 8'(fill);
      sum = sum + b;
      push_stray(stray_pct);
      push_item(OP_BYTE, b);
    end
    b = 8'd0 - sum;
    if (kind == FR_BAD_SUM || kind == FR_BAD_BOTH) b = b + 8'($urandom_range(1, 255));
    push_stray(stray_pct);
    push_item(OP_BYTE, b);
    b = END_BYTE;
    if (kind == FR_BAD_END || kind == FR_BAD_BOTH) begin
      do b = 8'($urandom); while (b == END_BYTE);
    end
    push_stray(stray_pct);
    push_item(OP_BYTE, b);
  endtask

  // Mostly whole frames with random payload, the rest noise, polls,
  // ticks, spare ops and frames cut short.
  task automatic push_traffic(input int target);
    int goal;
    int r;
    int k;
    frame_kind_t kind;
    goal = useful_queued + target;
    while (useful_queued < goal) begin
      r = $urandom_range(0, 99);
      if (r < 62) begin
        k = $urandom_range(0, 9);
        kind = (k < 7) ? FR_GOOD : (k == 7) ? FR_BAD_END : (k == 8) ? FR_BAD_SUM : FR_BAD_BOTH;
        push_frame(kind, -1, 6);
      end else if (r < 70) begin
        // line noise; now and then an STX that throws the framing off
        repeat ($urandom_range(1, 4))
          push_item(OP_BYTE, ($urandom_range(0, 9) == 0) ? 8'($urandom) : not_start());
      end else if (r < 80) begin
        push_item(OP_IDLE, 8'($urandom));
        repeat ($urandom_range(0, 6)) push_item(OP_TICK, 8'($urandom));
      end else if (r < 86) begin
        repeat ($urandom_range(1, 3)) push_item(OP_TICK, 8'($urandom));
      end else if (r < 92) begin
        // truncated frame: the next frame's bytes get swallowed into it
        push_item(OP_BYTE, START_BYTE);
        repeat ($urandom_range(1, FRAME_LEN - 3)) push_item(OP_BYTE, 8'($urandom));
      end else if (r < 96) begin
        push_item(OP_SPARE, 8'($urandom));
      end else begin
        push_item(OP_IDLE, 8'($urandom));
        push_item(OP_BYTE, 8'($urandom));
      end
    end
  endtask

  // hold the stream until every item is in and every result is out
  task automatic drain();
    while (items_taken != items_queued || due_results.size() != 0) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: changes on the falling edge, holds an item until it is taken
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    sfr_item_t nxt;
    if (!rst_n) begin
      in_ch.valid  <= 1'b0;
      out_ch.ready <= 1'b0;
    end else begin
      if (!in_ch.valid || in_took) begin
        if (stream_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          nxt = stream_q.pop_front();
          in_ch.valid   <= 1'b1;
          in_ch.op      <= nxt.op;
          in_ch.rx_byte <= nxt.rx_byte;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
      out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: predicts on input accept, checks on output accept
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    sfr_result_t want;
    sfr_result_t got;
    sfr_item_t   taken;
    if (!rst_n) begin
      in_took <= 1'b0;
    end else begin
      in_took <= in_ch.valid && in_ch.ready;
      if (in_ch.valid && in_ch.ready) begin
        taken.op      = in_ch.op;
        taken.rx_byte = in_ch.rx_byte;
        track_frame(taken, want);
        due_results.push_back(want);
        items_taken++;
      end
      if (out_ch.valid && out_ch.ready) begin
        got.byte_out    = out_ch.byte_out;
        got.byte_pos    = out_ch.byte_pos;
        got.byte_kept   = out_ch.byte_kept;
        got.frame_end   = out_ch.frame_end;
        got.frame_good  = out_ch.frame_good;
        got.error_total = out_ch.error_total;
        got.link_lost   = out_ch.link_lost;
        got.lost_ticks  = out_ch.lost_ticks;
        results_seen++;
        if (due_results.size() == 0) begin
          bad_results++;
          if (bad_results <= 10)
            $display("%0t: result %0d with nothing expected: byte %02h pos %0d", $realtime,
                     results_seen, got.byte_out, got.byte_pos);
        end else begin
          want = due_results.pop_front();
          if (got !== want) begin
            bad_results++;
            if (bad_results <= 10) begin
              $display("%0t: result %0d exp byte %02h pos %0d kept %b end %b good %b err %0d lost %b ticks %0d",
                       $realtime, results_seen,
                       want.byte_out, want.byte_pos, want.byte_kept, want.frame_end,
                       want.frame_good, want.error_total, want.link_lost, want.lost_ticks);
              $display("%0t: result %0d got byte %02h pos %0d kept %b end %b good %b err %0d lost %b ticks %0d",
                       $realtime, results_seen,
                       got.byte_out, got.byte_pos, got.byte_kept, got.frame_end,
                       got.frame_good, got.error_total, got.link_lost, got.lost_ticks);
            end
          end
        end
      end
    end
  end

  // watchdog
  int unsigned cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d items still owed", cycle_count,
               due_results.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.op      = OP_BYTE;
    in_ch.rx_byte = 8'd0;
    out_ch.ready  = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;
    @(posedge clk);

    // phase 1: sender mostly busy, receiver stalling heavily
    send_idle_pct = 14;
    recv_idle_pct = 80;

    // directed: tick while link is up, extreme hunt bytes, poll then ticks,
    // spare op, then a frame of all-ones payload (first byte revives the link)
    push_item(OP_TICK, 8'hFF);
    push_item(OP_BYTE, 8'hFF);
    push_item(OP_BYTE, 8'h00);
    push_item(OP_IDLE, 8'h00);
    push_item(OP_TICK, 8'hFF);
    push_item(OP_TICK, 8'h00);
    push_item(OP_SPARE, 8'hFF);
    push_frame(FR_GOOD, 8'hFF, 0);
    push_traffic(350);
    drain();   // sender sits idle until the receiver has caught up

    // phase 2: sender sparse, receiver mostly ready
    @(posedge clk);
    send_idle_pct = 80;
    recv_idle_pct = 14;
    push_traffic(400);
    drain();

    // phase 3: back to back; a run of hunt errors cleared by a good frame,
    // then lost time cleared by a byte
    @(posedge clk);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    push_traffic(340);
    repeat (6) push_item(OP_BYTE, not_start());
    push_frame(FR_GOOD, -1, 0);
    push_item(OP_IDLE, 8'($urandom));
    repeat (6) push_item(OP_TICK, 8'($urandom));
    push_item(OP_BYTE, not_start());
    push_traffic(20);
    drain();
    repeat (8) @(posedge clk);

    $display("%0d items in, %0d results checked; frames good %0d, bad %0d",
             items_taken, results_seen, frames_good, frames_bad);
    $display("%0d hunt bytes dropped, peak error count %0d, peak lost ticks %0d, %0d mismatches",
             hunt_drops, peak_err, peak_ticks, bad_results);
    if (bad_results == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/sfr_pkg.sv
rtl/core/sfr_in_if.sv
rtl/core/sfr_out_if.sv
rtl/core/sfr_in_reg.sv
rtl/core/sfr_frame_core.sv
rtl/core/sfr_out_reg.sv
rtl/core/stx_etx_frame_receiver.sv
rtl/core/sfr_checker.sv
tb/tb.sv
